// ----- rtl/scu_pkg.sv -----
// package: command codes and payload types for the simd compare unit
package scu_pkg;

    typedef enum logic [3:0] {
        CMD_SLT    = 4'd0,
        CMD_SLTI   = 4'd1,
        CMD_SLTIU  = 4'd2,
        CMD_SLTU   = 4'd3,
        CMD_PCEQB  = 4'd4,
        CMD_PCEQH  = 4'd5,
        CMD_PCEQW  = 4'd6,
        CMD_PCGTB  = 4'd7,
        CMD_PCGTH  = 4'd8,
        CMD_PCGTW  = 4'd9,
        CMD_FEQ    = 4'd10,
        CMD_FFALSE = 4'd11,
        CMD_FLE    = 4'd12,
        CMD_FLT    = 4'd13
    } cmd_t;

    localparam int InWidth  = 4 + 64 * 4 + 16 + 1;
    localparam int InBytes  = (InWidth + 7) / 8;
    localparam int OutWidth = 64 * 2 + 5;
    localparam int OutBytes = (OutWidth + 7) / 8;

    typedef struct packed {
        logic [63:0] res_high;
        logic [63:0] res_low;
        logic        write_reg;
        logic        write_upper;
        logic        cond_write;
        logic        cond_value;
        logic        unusable_fault;
    } result_t;

endpackage

// ----- rtl/simd_compare_unit.sv -----
// top level: registered single-pass compare unit
//
// One request is accepted every cycle while s_tready is high. Each request
// passes through an input register, one level of compare logic (64-bit
// magnitude compare, packed lane compares, single-precision compare) and a
// result register, and is presented on m_tvalid from the result register.
// One skid entry behind the result register keeps input acceptance going
// for one more request while the output is stalled; once the skid entry is
// full, s_tready drops until the receiver takes a result.
module simd_compare_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd[3:0], src_a_low[67:4], src_a_high[131:68], src_b_low[195:132],
    // src_b_high[259:196], immediate[275:260], fpu_usable[276], zero fill
    input  logic [scu_pkg::InBytes*8-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // res_low[63:0], res_high[127:64], write_reg[128], write_upper[129],
    // cond_write[130], cond_value[131], unusable_fault[132], zero fill
    output logic [scu_pkg::OutBytes*8-1:0]   m_tdata
);
    import scu_pkg::*;

    // input stage
    logic          in_vld_reg;
    logic [3:0]    cmd_reg;
    logic [63:0]   al_reg, ah_reg, bl_reg, bh_reg;
    logic [15:0]   imm_reg;
    logic          usable_reg;
    // result stage plus skid entry
    logic          out_vld_reg, skid_vld_reg;
    result_t       out_reg, skid_reg, res;
    logic          adv;

    // pipeline moves when skid is free
    assign s_tready = !skid_vld_reg;
    assign adv      = !skid_vld_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_tvalid;
        end
        if (adv && s_tvalid) begin
            cmd_reg    <= s_tdata[3:0];
            al_reg     <= s_tdata[67:4];
            ah_reg     <= s_tdata[131:68];
            bl_reg     <= s_tdata[195:132];
            bh_reg     <= s_tdata[259:196];
            imm_reg    <= s_tdata[275:260];
            usable_reg <= s_tdata[276];
        end
    end

    // packed lane compare on one half
    function automatic logic [63:0] lane_cmp(input logic [63:0] a, input logic [63:0] b,
                                             input logic [1:0] sz, input logic gt);
        logic [63:0] r;
        r = '0;
        case (sz)
            2'd0: begin
                for (int i = 0; i < 8; i++) begin
                    r[i*8 +: 8] = (gt ? ($signed(a[i*8 +: 8]) > $signed(b[i*8 +: 8]))
                                      : (a[i*8 +: 8] == b[i*8 +: 8])) ? 8'hFF : 8'h00;
                end
            end
            2'd1: begin
                for (int i = 0; i < 4; i++) begin
                    r[i*16 +: 16] = (gt ? ($signed(a[i*16 +: 16]) > $signed(b[i*16 +: 16]))
                                        : (a[i*16 +: 16] == b[i*16 +: 16])) ? 16'hFFFF : 16'h0;
                end
            end
            default: begin
                for (int i = 0; i < 2; i++) begin
                    r[i*32 +: 32] = (gt ? ($signed(a[i*32 +: 32]) > $signed(b[i*32 +: 32]))
                                        : (a[i*32 +: 32] == b[i*32 +: 32])) ? 32'hFFFFFFFF
                                                                             : 32'h0;
                end
            end
        endcase
        return r;
    endfunction

    // compare logic
    logic [63:0] imm_ext;
    logic [31:0] fa, fb, ka, kb;
    logic        nan_a, nan_b, zz, f_eq, f_lt, slt_s, slt_u, slti_s, slti_u;
    logic [1:0]  sz;
    logic        gt;

    always_comb begin
        imm_ext = {{48{imm_reg[15]}}, imm_reg};
        slt_s   = $signed(al_reg) < $signed(bl_reg);
        slt_u   = al_reg < bl_reg;
        slti_s  = $signed(al_reg) < $signed(imm_ext);
        slti_u  = al_reg < imm_ext;
        fa      = al_reg[31:0];
        fb      = bl_reg[31:0];
        nan_a   = (fa[30:23] == 8'hFF) && (fa[22:0] != '0);
        nan_b   = (fb[30:23] == 8'hFF) && (fb[22:0] != '0);
        zz      = (fa[30:0] == '0) && (fb[30:0] == '0);
        ka      = fa[31] ? ~fa : (fa | 32'h80000000);
        kb      = fb[31] ? ~fb : (fb | 32'h80000000);
        f_eq    = !nan_a && !nan_b && (zz || (fa == fb));
        f_lt    = !nan_a && !nan_b && !zz && (ka < kb);
        sz      = 2'd0;
        gt      = 1'b0;
        res     = '0;
        case (cmd_reg)
            CMD_SLT:   begin res.res_low = {63'd0, slt_s};  res.write_reg = 1'b1; end
            CMD_SLTI:  begin res.res_low = {63'd0, slti_s}; res.write_reg = 1'b1; end
            CMD_SLTIU: begin res.res_low = {63'd0, slti_u}; res.write_reg = 1'b1; end
            CMD_SLTU:  begin res.res_low = {63'd0, slt_u};  res.write_reg = 1'b1; end
            CMD_PCEQB, CMD_PCEQH, CMD_PCEQW, CMD_PCGTB, CMD_PCGTH, CMD_PCGTW: begin
                case (cmd_reg)
                    CMD_PCEQB, CMD_PCGTB: sz = 2'd0;
                    CMD_PCEQH, CMD_PCGTH: sz = 2'd1;
                    default:              sz = 2'd2;
                endcase
                gt = (cmd_reg >= CMD_PCGTB);
                res.res_low     = lane_cmp(al_reg, bl_reg, sz, gt);
                res.res_high    = lane_cmp(ah_reg, bh_reg, sz, gt);
                res.write_reg   = 1'b1;
                res.write_upper = 1'b1;
            end
            CMD_FEQ, CMD_FFALSE, CMD_FLE, CMD_FLT: begin
                if (!usable_reg) begin
                    res.unusable_fault = 1'b1;
                end else begin
                    res.cond_write = 1'b1;
                    case (cmd_reg)
                        CMD_FEQ: res.cond_value = f_eq;
                        CMD_FLE: res.cond_value = f_eq || f_lt;
                        CMD_FLT: res.cond_value = f_lt;
                        default: res.cond_value = 1'b0;
                    endcase
                end
            end
            default: res = '0;
        endcase
    end

    // result register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (skid_vld_reg) begin
                if (m_tready) begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
            end else if (out_vld_reg && !m_tready) begin
                skid_vld_reg <= in_vld_reg;
            end else begin
                out_vld_reg <= in_vld_reg;
            end
        end
        if (skid_vld_reg) begin
            if (m_tready) out_reg <= skid_reg;
        end else if (out_vld_reg && !m_tready) begin
            skid_reg <= res;
        end else begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OutBytes*8-OutWidth){1'b0}},
                       out_reg.unusable_fault, out_reg.cond_value, out_reg.cond_write,
                       out_reg.write_upper, out_reg.write_reg,
                       out_reg.res_high, out_reg.res_low};

    // skid entry is only filled behind a held result
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg) else $error("skid valid without output valid");
    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_tready) |=> (out_vld_reg && $stable(out_reg)))
        else $error("stalled result changed");
    // float fault excludes any write
    a_fault_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_reg.unusable_fault) |->
        !(out_reg.write_reg || out_reg.cond_write)) else $error("fault with write");
    // upper write only with register write
    a_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_reg.write_upper) |-> out_reg.write_reg)
        else $error("upper write without register write");

endmodule

// ----- tb/tb_simd_compare_unit.sv -----
// testbench: simd compare unit, random and directed compares against a behavioral predictor
module tb_simd_compare_unit;
    import scu_pkg::*;

    typedef struct {
        logic [3:0]  cmd;
        logic [63:0] al, ah, bl, bh;
        logic [15:0] imm;
        logic        usable;
    } req_t;

    typedef struct {
        logic [63:0] rl, rh;
        logic wr, wu, cw, cv, fault;
    } res_t;

    localparam int CycleLimit = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [InBytes*8-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OutBytes*8-1:0] m_tdata;

    res_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;

    simd_compare_unit dut (.*);

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver readiness
    always @(posedge aclk) begin
        if (recv_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // packed lane compare over one half
    function automatic logic [63:0] lane_compare(logic [63:0] a, logic [63:0] b,
                                                 int lane, bit gt);
        logic [63:0] out;
        logic signed [32:0] x, y;
        out = '0;
        for (int sh = 0; sh < 64; sh += lane) begin
            x = '0;
            y = '0;
            for (int i = 0; i < lane; i++) begin
                x[i] = a[sh + i];
                y[i] = b[sh + i];
            end
            for (int i = lane; i < 33; i++) begin
                x[i] = x[lane - 1];
                y[i] = y[lane - 1];
            end
            if (gt ? (x > y) : (x == y))
                for (int i = 0; i < lane; i++) out[sh + i] = 1'b1;
        end
        return out;
    endfunction

    function automatic bit is_nan(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function automatic logic [31:0] order_key(logic [31:0] v);
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    // expected outcome of one request
    function automatic res_t compute_compare(req_t r);
        res_t o;
        logic [63:0] simm;
        bit eq, lt;
        int lane;
        o = '{default: '0};
        simm = {{48{r.imm[15]}}, r.imm};
        case (r.cmd)
            CMD_SLT: begin o.rl = {63'd0, $signed(r.al) < $signed(r.bl)}; o.wr = 1; end
            CMD_SLTI: begin o.rl = {63'd0, $signed(r.al) < $signed(simm)}; o.wr = 1; end
            CMD_SLTIU: begin o.rl = {63'd0, r.al < simm}; o.wr = 1; end
            CMD_SLTU: begin o.rl = {63'd0, r.al < r.bl}; o.wr = 1; end
            CMD_PCEQB, CMD_PCEQH, CMD_PCEQW, CMD_PCGTB, CMD_PCGTH, CMD_PCGTW: begin
                lane = 8 << ((r.cmd - 4) % 3);
                o.rl = lane_compare(r.al, r.bl, lane, r.cmd >= CMD_PCGTB);
                o.rh = lane_compare(r.ah, r.bh, lane, r.cmd >= CMD_PCGTB);
                o.wr = 1;
                o.wu = 1;
            end
            CMD_FEQ, CMD_FFALSE, CMD_FLE, CMD_FLT: begin
                if (!r.usable) begin
                    o.fault = 1;
                end else begin
                    o.cw = 1;
                    if (is_nan(r.al[31:0]) || is_nan(r.bl[31:0])) begin
                        eq = 0;
                        lt = 0;
                    end else if (r.al[30:0] == 0 && r.bl[30:0] == 0) begin
                        eq = 1;
                        lt = 0;
                    end else begin
                        eq = r.al[31:0] == r.bl[31:0];
                        lt = order_key(r.al[31:0]) < order_key(r.bl[31:0]);
                    end
                    if (r.cmd == CMD_FEQ) o.cv = eq;
                    else if (r.cmd == CMD_FLE) o.cv = eq || lt;
                    else if (r.cmd == CMD_FLT) o.cv = lt;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        res_t e;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[OutWidth-1:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'h0);
            end else begin
                e = expected_results.pop_front();
                got = '{res_high: m_tdata[127:64], res_low: m_tdata[63:0],
                        write_reg: m_tdata[128], write_upper: m_tdata[129],
                        cond_write: m_tdata[130], cond_value: m_tdata[131],
                        unusable_fault: m_tdata[132]};
                if (got.res_low !== e.rl) report_mismatch("res_low", got.res_low, e.rl);
                if (got.res_high !== e.rh) report_mismatch("res_high", got.res_high, e.rh);
                if (got.write_reg !== e.wr) report_mismatch("write_reg", got.write_reg, e.wr);
                if (got.write_upper !== e.wu)
                    report_mismatch("write_upper", got.write_upper, e.wu);
                if (got.cond_write !== e.cw)
                    report_mismatch("cond_write", got.cond_write, e.cw);
                if (got.cond_value !== e.cv)
                    report_mismatch("cond_value", got.cond_value, e.cv);
                if (got.unusable_fault !== e.fault)
                    report_mismatch("unusable_fault", got.unusable_fault, e.fault);
            end
        end
    end

    // send one request, with random idle cycles before it
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, r.usable, r.imm, r.bh, r.bl, r.ah, r.al, r.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(compute_compare(r));
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random float with bias toward zeros, infinities, nans and subnormals
    function automatic logic [31:0] rand_float();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 31'h0};
            1: return {1'($urandom_range(1)), 8'hFF, 23'h0};
            2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
            3: return {1'($urandom_range(1)), 8'h0, 23'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    // lane-biased operand: b keeps some bits of a, chosen by a random mask
    function automatic logic [63:0] mix_lanes(logic [63:0] a);
        logic [63:0] b, m;
        b = rand64();
        m = rand64() & rand64();
        return (a & ~m) | (b & m);
    endfunction

    function automatic req_t rand_request();
        req_t r;
        r.cmd = 4'($urandom_range(15));
        r.al = rand64();
        r.ah = rand64();
        r.imm = 16'($urandom());
        r.usable = $urandom_range(7) != 0;
        case ($urandom_range(3))
            0: begin r.bl = r.al; r.bh = r.ah; end
            1: begin r.bl = mix_lanes(r.al); r.bh = mix_lanes(r.ah); end
            default: begin r.bl = rand64(); r.bh = rand64(); end
        endcase
        if (r.cmd >= CMD_FEQ && r.cmd <= CMD_FLT) begin
            r.al[31:0] = rand_float();
            r.bl[31:0] = ($urandom_range(3) == 0) ? r.al[31:0] : rand_float();
        end
        if ($urandom_range(7) == 0) r.al = 64'($signed(r.imm)) + $urandom_range(2) - 1;
        return r;
    endfunction

    function automatic req_t make_request(logic [3:0] c, logic [63:0] al, logic [63:0] bl,
                                          logic [15:0] imm, logic u);
        req_t r;
        r = '{cmd: c, al: al, ah: ~al, bl: bl, bh: ~bl, imm: imm, usable: u};
        return r;
    endfunction

    // directed: field extremes, every command, float special cases
    task automatic test_directed();
        send_request(make_request(CMD_SLT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                  16'h0, 1'b1));
        send_request(make_request(CMD_SLTU, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                  16'h0, 1'b1));
        send_request(make_request(CMD_SLTI, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 16'h8000, 1'b1));
        send_request(make_request(CMD_SLTI, 64'h0, 64'h0, 16'h7FFF, 1'b0));
        send_request(make_request(CMD_SLTIU, 64'h0000_FFFF_FFFF_FFFF, 64'h0, 16'hFFFF, 1'b1));
        send_request(make_request(CMD_SLTIU, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'hFFFF, 1'b1));
        send_request(make_request(CMD_PCEQB, 64'h00FF_1234_8000_7F01, 64'h00FE_1234_8000_7F01,
                                  16'h0, 1'b1));
        send_request(make_request(CMD_PCEQH, '1, '1, 16'h0, 1'b1));
        send_request(make_request(CMD_PCEQW, 64'h0, 64'h1, 16'h0, 1'b1));
        send_request(make_request(CMD_PCGTB, 64'h807F_0180_FF00_7F80, 64'h7F80_0001_00FF_807F,
                                  16'h0, 1'b1));
        send_request(make_request(CMD_PCGTH, 64'h8000_7FFF_0000_FFFF, 64'h7FFF_8000_FFFF_0000,
                                  16'h0, 1'b1));
        send_request(make_request(CMD_PCGTW, 64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000,
                                  16'h0, 1'b1));
        send_request(make_request(CMD_FEQ, 64'h8000_0000, 64'h0, 16'h0, 1'b1));
        send_request(make_request(CMD_FLE, 64'h8000_0000, 64'h0, 16'h0, 1'b1));
        send_request(make_request(CMD_FLT, 64'hBF80_0000, 64'h3F80_0000, 16'h0, 1'b1));
        send_request(make_request(CMD_FLT, 64'hC000_0000, 64'hBF80_0000, 16'h0, 1'b1));
        send_request(make_request(CMD_FEQ, 64'h7FC0_0000, 64'h7FC0_0000, 16'h0, 1'b1));
        send_request(make_request(CMD_FLE, 64'h7F80_0001, 64'h3F80_0000, 16'h0, 1'b1));
        send_request(make_request(CMD_FLT, 64'hFF80_0000, 64'h7F80_0000, 16'h0, 1'b1));
        send_request(make_request(CMD_FFALSE, 64'h3F80_0000, 64'h3F80_0000, 16'h0, 1'b1));
        send_request(make_request(CMD_FEQ, 64'h3F80_0000, 64'h3F80_0000, 16'h0, 1'b0));
        send_request(make_request(CMD_FFALSE, 64'h0, 64'h0, 16'h0, 1'b0));
        send_request(make_request(4'd14, '1, '1, 16'hFFFF, 1'b1));
        send_request(make_request(4'd15, '1, '1, 16'hFFFF, 1'b0));
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count) send_request(rand_request());
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (60) @(posedge aclk);
                recv_hold = 1'b0;
            end
            repeat (30) send_request(rand_request());
        join
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 32;
        recv_idle_pct = 72;
        test_random(500);
        send_idle_pct = 72;
        recv_idle_pct = 32;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(470);
        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/scu_pkg.sv
rtl/simd_compare_unit.sv
tb/tb_simd_compare_unit.sv
